// File: rtl/core/fifo_with_remove_by_key_macros.svh
// Assertion macros used by the checker of this block.
`ifndef FIFO_WITH_REMOVE_BY_KEY_MACROS_SVH
`define FIFO_WITH_REMOVE_BY_KEY_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define FWRK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("fwrk assertion failed");

// Next-cycle implication, disabled while reset is low.
`define FWRK_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("fwrk assertion failed");

`endif

// File: rtl/core/fwrk_pkg.sv
package fwrk_pkg;

	localparam int MODE_W   = 2;
	localparam int ID_W     = 16;
	localparam int HANDLE_W = 16;
	localparam int STAT_W   = 2;
	localparam int OCC_W    = 7;

	localparam int QUEUE_DEPTH_DEFAULT = 64;

	// cells per group in the first-match prefix
	localparam int GROUP_W = 8;

	typedef enum logic [MODE_W-1:0] {
		MODE_ENQ = 2'd0,
		MODE_DEQ = 2'd1,
		MODE_REM = 2'd2
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_MISS  = 2'd3
	} stat_t;

	// broadcast to every cell of the row
	typedef struct packed {
		logic load;     // write the op payload into the cell at the fill count
		logic pop;      // every cell takes its neighbor's entry
		logic squeeze;  // cells at or past the first match take their neighbor's entry
		logic probe;    // compare stored id against the key
	} cell_ctrl_t;

endpackage

// File: rtl/core/fwrk_if.sv
interface fwrk_op_if;
	logic                          valid;
	logic                          ready;
	logic [fwrk_pkg::MODE_W-1:0]   mode;
	logic [fwrk_pkg::ID_W-1:0]     proc_id;
	logic [fwrk_pkg::HANDLE_W-1:0] proc_handle;

	modport source (output valid, mode, proc_id, proc_handle, input ready);
	modport sink   (input valid, mode, proc_id, proc_handle, output ready);
endinterface

interface fwrk_res_if;
	logic                          valid;
	logic                          ready;
	logic [fwrk_pkg::STAT_W-1:0]   status;
	logic [fwrk_pkg::ID_W-1:0]     out_id;
	logic [fwrk_pkg::HANDLE_W-1:0] out_handle;
	logic [fwrk_pkg::OCC_W-1:0]    occupancy;
	logic                          is_empty;

	modport source (output valid, status, out_id, out_handle, occupancy, is_empty,
		input ready);
	modport sink   (input valid, status, out_id, out_handle, occupancy, is_empty,
		output ready);
endinterface

// File: rtl/core/fwrk_cell.sv
module fwrk_cell #(
	parameter int IDX = 0,
	parameter int CW  = 7
) (
	input  logic                          clk,
	input  fwrk_pkg::cell_ctrl_t          ctrl,
	input  logic [CW-1:0]                 count,
	input  logic [fwrk_pkg::ID_W-1:0]     key,
	input  logic [fwrk_pkg::HANDLE_W-1:0] load_handle,
	input  logic [fwrk_pkg::ID_W-1:0]     nxt_id,
	input  logic [fwrk_pkg::HANDLE_W-1:0] nxt_handle,
	input  logic                          squeeze_en,
	output logic [fwrk_pkg::ID_W-1:0]     id,
	output logic [fwrk_pkg::HANDLE_W-1:0] handle,
	output logic                          match
);

	logic [fwrk_pkg::ID_W-1:0]     id_q;
	logic [fwrk_pkg::HANDLE_W-1:0] handle_q;
	logic                          match_q;
	logic                          occupied;
	logic                          at_tail;

	assign occupied = CW'(IDX) < count;
	assign at_tail  = CW'(IDX) == count;

	always_ff @(posedge clk) begin
		if (ctrl.load && at_tail) begin
			id_q     <= key;
			handle_q <= load_handle;
		end else if (ctrl.pop || (ctrl.squeeze && squeeze_en)) begin
			id_q     <= nxt_id;
			handle_q <= nxt_handle;
		end
		if (ctrl.probe) begin
			match_q <= occupied && (id_q == key);
		end
	end

	assign id     = id_q;
	assign handle = handle_q;
	assign match  = match_q;

endmodule

// File: rtl/core/fwrk_scan.sv
module fwrk_scan #(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             capture,
	input  logic [DEPTH-1:0] match,
	output logic [DEPTH-1:0] prefix,
	output logic             hit
);

	localparam int GW     = fwrk_pkg::GROUP_W;
	localparam int GROUPS = (DEPTH + GW - 1) / GW;
	localparam int PW     = GROUPS * GW;

	logic [PW-1:0]     mpad;
	logic [PW-1:0]     lp;
	logic [GROUPS-1:0] grp_any;
	logic [PW-1:0]     lp_q;
	logic [GROUPS-1:0] any_q;
	logic [PW-1:0]     prefix_pad;

	// prefix OR inside each group of cells
	always_comb begin
		logic run;
		mpad = '0;
		mpad[DEPTH-1:0] = match;
		lp = '0;
		grp_any = '0;
		for (int g = 0; g < GROUPS; g++) begin
			run = 1'b0;
			for (int k = 0; k < GW; k++) begin
				run = run | mpad[g*GW+k];
				lp[g*GW+k] = run;
			end
			grp_any[g] = run;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			lp_q  <= lp;
			any_q <= grp_any;
		end
	end

	// fold in any hit from an earlier group
	always_comb begin
		logic below;
		prefix_pad = '0;
		for (int g = 0; g < GROUPS; g++) begin
			below = 1'b0;
			for (int k = 0; k < GROUPS; k++) begin
				if (k < g) begin
					below = below | any_q[k];
				end
			end
			for (int k = 0; k < GW; k++) begin
				prefix_pad[g*GW+k] = lp_q[g*GW+k] | below;
			end
		end
	end

	assign prefix = prefix_pad[DEPTH-1:0];
	assign hit    = |any_q;

endmodule

// File: rtl/core/fifo_with_remove_by_key.sv
// Bounded FIFO of (process id, handle) entries held in a row of cells, head
// in cell 0. Enqueue writes the cell at the fill count; dequeue and remove
// shift stored entries one cell toward the head, so entries always keep their order.
// Enqueue, dequeue and an unused mode give a valid result in the cycle after
// accept. When the queue is not empty, remove runs in steps: every cell
// compares its id with the key, a registered group prefix picks the first
// match, then the cells at and after it take their neighbor's entry. A new
// operation is accepted once the block is idle and the result register is
// free or being read in the same cycle. Storage needs no clearing after
// reset; only the fill count, the state and the result valid flag are reset.
module fifo_with_remove_by_key #(
	parameter int QUEUE_DEPTH = fwrk_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	fwrk_op_if.sink    op,
	fwrk_res_if.source res
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQUEEZE
	} state_t;

	state_t state_q, state_nx;
	logic [CW-1:0] count_q, cnt_nx;
	logic          res_valid_q;
	fwrk_pkg::stat_t               res_stat_q, stat_nx;
	logic [fwrk_pkg::ID_W-1:0]     res_id_q, oid_nx;
	logic [fwrk_pkg::HANDLE_W-1:0] res_handle_q, ohd_nx;
	logic [fwrk_pkg::OCC_W-1:0]    res_occ_q;
	logic                          res_empty_q;
	logic [CW+fwrk_pkg::OCC_W-1:0] occ_ext;

	fwrk_pkg::cell_ctrl_t ctrl;
	logic op_fire;
	logic done;
	logic full;
	logic empty;

	logic [fwrk_pkg::ID_W-1:0]     id_w     [QUEUE_DEPTH];
	logic [fwrk_pkg::HANDLE_W-1:0] handle_w [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]        match_w;
	logic [QUEUE_DEPTH-1:0]        prefix_w;
	logic                          hit;

	assign op.ready = (state_q == ST_IDLE) && (!res_valid_q || res.ready);
	assign op_fire  = op.valid && op.ready;
	assign full     = count_q >= CW'(QUEUE_DEPTH);
	assign empty    = count_q == '0;

	for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
		logic [fwrk_pkg::ID_W-1:0]     nxt_id;
		logic [fwrk_pkg::HANDLE_W-1:0] nxt_handle;
		if (j == QUEUE_DEPTH - 1) begin : g_last
			assign nxt_id     = '0;
			assign nxt_handle = '0;
		end else begin : g_mid
			assign nxt_id     = id_w[j+1];
			assign nxt_handle = handle_w[j+1];
		end
		fwrk_cell #(
			.IDX (j),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.count       (count_q),
			.key         (op.proc_id),
			.load_handle (op.proc_handle),
			.nxt_id      (nxt_id),
			.nxt_handle  (nxt_handle),
			.squeeze_en  (prefix_w[j]),
			.id          (id_w[j]),
			.handle      (handle_w[j]),
			.match       (match_w[j])
		);
	end

	fwrk_scan #(
		.DEPTH (QUEUE_DEPTH)
	) u_scan (
		.clk     (clk),
		.capture (state_q == ST_SCAN),
		.match   (match_w),
		.prefix  (prefix_w),
		.hit     (hit)
	);

	always_comb begin
		ctrl     = '0;
		done     = 1'b0;
		state_nx = state_q;
		cnt_nx   = count_q;
		stat_nx  = fwrk_pkg::STAT_OK;
		oid_nx   = '0;
		ohd_nx   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (op_fire) begin
					case (fwrk_pkg::mode_t'(op.mode))
						fwrk_pkg::MODE_ENQ: begin
							done = 1'b1;
							if (full) begin
								stat_nx = fwrk_pkg::STAT_FULL;
							end else begin
								ctrl.load = 1'b1;
								cnt_nx    = count_q + 1'b1;
							end
						end
						fwrk_pkg::MODE_DEQ: begin
							done = 1'b1;
							if (empty) begin
								stat_nx = fwrk_pkg::STAT_EMPTY;
							end else begin
								ctrl.pop = 1'b1;
								oid_nx   = id_w[0];
								ohd_nx   = handle_w[0];
								cnt_nx   = count_q - 1'b1;
							end
						end
						fwrk_pkg::MODE_REM: begin
							if (empty) begin
								done    = 1'b1;
								stat_nx = fwrk_pkg::STAT_EMPTY;
							end else begin
								ctrl.probe = 1'b1;
								state_nx   = ST_SCAN;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				state_nx = ST_SQUEEZE;
			end
			ST_SQUEEZE: begin
				done     = 1'b1;
				state_nx = ST_IDLE;
				if (hit) begin
					ctrl.squeeze = 1'b1;
					cnt_nx       = count_q - 1'b1;
				end else begin
					stat_nx = fwrk_pkg::STAT_MISS;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	assign occ_ext = {{fwrk_pkg::OCC_W{1'b0}}, cnt_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			count_q <= cnt_nx;
			if (done) begin
				res_valid_q  <= 1'b1;
				res_stat_q   <= stat_nx;
				res_id_q     <= oid_nx;
				res_handle_q <= ohd_nx;
				res_occ_q    <= occ_ext[fwrk_pkg::OCC_W-1:0];
				res_empty_q  <= cnt_nx == '0;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = res_valid_q;
	assign res.status     = res_stat_q;
	assign res.out_id     = res_id_q;
	assign res.out_handle = res_handle_q;
	assign res.occupancy  = res_occ_q;
	assign res.is_empty   = res_empty_q;

endmodule

// File: rtl/core/fwrk_checker.sv
`include "fifo_with_remove_by_key_macros.svh"

module fwrk_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [fwrk_pkg::STAT_W-1:0]   status,
	input logic [fwrk_pkg::ID_W-1:0]     out_id,
	input logic [fwrk_pkg::HANDLE_W-1:0] out_handle,
	input logic [fwrk_pkg::OCC_W-1:0]    occupancy,
	input logic                          is_empty
);

	// a stalled result beat stays up
	`FWRK_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

	// an empty queue reports zero occupancy
	`FWRK_ASSERT_IMP(a_empty_occ, clk, arst_n, res_valid && is_empty, occupancy == '0)

	// only a successful dequeue returns entry data
	`FWRK_ASSERT_IMP(a_data_ok, clk, arst_n,
		res_valid && ((out_id != '0) || (out_handle != '0)), status == fwrk_pkg::STAT_OK)

	// full and empty reports agree with the empty flag
	`FWRK_ASSERT_IMP(a_full_flag, clk, arst_n,
		res_valid && (status == fwrk_pkg::STAT_FULL), !is_empty)

	`FWRK_ASSERT_IMP(a_empty_flag, clk, arst_n,
		res_valid && (status == fwrk_pkg::STAT_EMPTY), is_empty)

endmodule

bind fifo_with_remove_by_key fwrk_checker u_fwrk_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.status     (res.status),
	.out_id     (res.out_id),
	.out_handle (res.out_handle),
	.occupancy  (res.occupancy),
	.is_empty   (res.is_empty)
);

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QDEPTH   = fwrk_pkg::QUEUE_DEPTH_DEFAULT;
	localparam int MODE_W   = fwrk_pkg::MODE_W;
	localparam int ID_W     = fwrk_pkg::ID_W;
	localparam int HANDLE_W = fwrk_pkg::HANDLE_W;
	localparam int OCC_W    = fwrk_pkg::OCC_W;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
	} proc_entry_t;

	typedef struct {
		fwrk_pkg::stat_t     status;
		logic [ID_W-1:0]     id;
		logic [HANDLE_W-1:0] handle;
		logic [OCC_W-1:0]    occ;
		logic                empty;
	} op_result_t;

	logic clk = 1'b0;
	logic arst_n;

	fwrk_op_if  op_bus ();
	fwrk_res_if res_bus ();

	fifo_with_remove_by_key #(.QUEUE_DEPTH(QDEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_bus),
		.res    (res_bus)
	);

	proc_entry_t queued_procs[$];
	op_result_t  pending_results[$];
	int error_count = 0;
	int op_max_gap = 6;
	int res_max_gap = 6;
	int hold_off_cycles = 0;

	always #5 clk = ~clk;

	// Queue contents as the block should hold them, head first.
	task automatic predict_op(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [HANDLE_W-1:0] h);
		op_result_t r;
		proc_entry_t e;
		int hit;
		r.status = fwrk_pkg::STAT_OK;
		r.id = '0;
		r.handle = '0;
		case (m)
			fwrk_pkg::MODE_ENQ: begin
				if (queued_procs.size() >= QDEPTH) begin
					r.status = fwrk_pkg::STAT_FULL;
				end else begin
					e.id = id;
					e.handle = h;
					queued_procs.push_back(e);
				end
			end
			fwrk_pkg::MODE_DEQ: begin
				if (queued_procs.size() == 0) begin
					r.status = fwrk_pkg::STAT_EMPTY;
				end else begin
					e = queued_procs.pop_front();
					r.id = e.id;
					r.handle = e.handle;
				end
			end
			fwrk_pkg::MODE_REM: begin
				if (queued_procs.size() == 0) begin
					r.status = fwrk_pkg::STAT_EMPTY;
				end else begin
					hit = -1;
					for (int i = 0; i < queued_procs.size() && hit < 0; i++)
						if (queued_procs[i].id == id)
							hit = i;
					if (hit < 0)
						r.status = fwrk_pkg::STAT_MISS;
					else
						queued_procs.delete(hit);
				end
			end
			default: ;
		endcase
		r.occ = OCC_W'(queued_procs.size());
		r.empty = (queued_procs.size() == 0);
		pending_results.push_back(r);
	endtask

	task automatic send_op(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
			input logic [HANDLE_W-1:0] h);
		int gap;
		gap = $urandom_range(0, op_max_gap);
		if (gap > 0) begin
			op_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		op_bus.valid       <= 1'b1;
		op_bus.mode        <= m;
		op_bus.proc_id     <= id;
		op_bus.proc_handle <= h;
		do @(posedge clk); while (!op_bus.ready);
		predict_op(m, id, h);
	endtask

	// Drop valid and hold until every outstanding result has come back.
	task automatic wait_drained();
		op_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [ID_W-1:0] rand_id();
		if ($urandom_range(0, 1))
			return ID_W'($urandom_range(0, 7));
		return ID_W'($urandom());
	endfunction

	function automatic logic [ID_W-1:0] pick_remove_key();
		if (queued_procs.size() != 0 && $urandom_range(0, 9) < 7)
			return queued_procs[$urandom_range(0, queued_procs.size() - 1)].id;
		return rand_id();
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		op_result_t exp_r;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual status %0d occ %0d",
					$time, res_bus.status, res_bus.occupancy);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 16'(exp_r.status), 16'(res_bus.status));
				check_field("out_id", exp_r.id, res_bus.out_id);
				check_field("out_handle", exp_r.handle, res_bus.out_handle);
				check_field("occupancy", 16'(exp_r.occ), 16'(res_bus.occupancy));
				check_field("is_empty", 16'(exp_r.empty), 16'(res_bus.is_empty));
			end
		end
	end

	// Result side: random stalls per beat, or one long hold-off when requested.
	initial begin
		int gap;
		res_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				res_bus.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end else begin
				gap = $urandom_range(0, res_max_gap);
				if (gap > 0) begin
					res_bus.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	task automatic test_corner_cases();
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_REM, 16'h0000, 16'hffff);
		send_op(MODE_UNUSED, 16'hffff, 16'hffff);
		send_op(fwrk_pkg::MODE_ENQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_ENQ, 16'hffff, 16'hffff);
		send_op(fwrk_pkg::MODE_ENQ, 16'h00ff, 16'hff00);
		send_op(fwrk_pkg::MODE_REM, 16'haaaa, 16'h5555);
		send_op(MODE_UNUSED, 16'h5555, 16'haaaa);
		send_op(fwrk_pkg::MODE_ENQ, 16'hffff, 16'h0001);
		// duplicate id: only the entry nearer the head goes
		send_op(fwrk_pkg::MODE_REM, 16'hffff, 16'h0000);
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_ENQ, 16'h1111, 16'h0a0a);
		send_op(fwrk_pkg::MODE_ENQ, 16'h2222, 16'h0b0b);
		send_op(fwrk_pkg::MODE_ENQ, 16'h3333, 16'h0c0c);
		send_op(fwrk_pkg::MODE_REM, 16'h3333, 16'h0000);
		send_op(fwrk_pkg::MODE_REM, 16'h1111, 16'h0000);
		send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
		send_op(fwrk_pkg::MODE_REM, 16'h2222, 16'h0000);
	endtask

	task automatic test_fill_under_backpressure();
		op_max_gap = 0;
		hold_off_cycles = 400;
		repeat (QDEPTH + 3)
			send_op(fwrk_pkg::MODE_ENQ, rand_id(), HANDLE_W'($urandom()));
		wait_drained();
		op_max_gap = 6;
		send_op(fwrk_pkg::MODE_REM, queued_procs[queued_procs.size() - 1].id, 16'h0000);
		send_op(fwrk_pkg::MODE_ENQ, 16'h8000, 16'h8000);
		send_op(fwrk_pkg::MODE_ENQ, 16'h7fff, 16'h7fff);
		send_op(fwrk_pkg::MODE_REM, queued_procs[0].id, 16'h0000);
		repeat (QDEPTH + 1)
			send_op(fwrk_pkg::MODE_DEQ, 16'h0000, 16'h0000);
	endtask

	task automatic test_random_mix();
		int pct;
		bit fill_bias;
		for (int round = 0; round < 8; round++) begin
			fill_bias = (round % 2 == 0);
			op_max_gap = $urandom_range(0, 1) ? 6 : 0;
			res_max_gap = $urandom_range(0, 1) ? 6 : 0;
			repeat (100) begin
				pct = $urandom_range(0, 99);
				if (pct < (fill_bias ? 60 : 20))
					send_op(fwrk_pkg::MODE_ENQ, rand_id(), HANDLE_W'($urandom()));
				else if (pct < (fill_bias ? 75 : 65))
					send_op(fwrk_pkg::MODE_DEQ, ID_W'($urandom()), HANDLE_W'($urandom()));
				else if (pct < 95)
					send_op(fwrk_pkg::MODE_REM, pick_remove_key(), HANDLE_W'($urandom()));
				else
					send_op(MODE_UNUSED, ID_W'($urandom()), HANDLE_W'($urandom()));
			end
			if (round % 3 == 2)
				wait_drained();
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		op_bus.valid       <= 1'b0;
		op_bus.mode        <= fwrk_pkg::MODE_ENQ;
		op_bus.proc_id     <= '0;
		op_bus.proc_handle <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		wait_drained();
		test_fill_under_backpressure();
		wait_drained();
		test_random_mix();
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// File: fifo_with_remove_by_key.f
+incdir+rtl/core
rtl/core/fwrk_pkg.sv
rtl/core/fwrk_if.sv
rtl/core/fwrk_cell.sv
rtl/core/fwrk_scan.sv
rtl/core/fifo_with_remove_by_key.sv
rtl/core/fwrk_checker.sv
verif/tb.sv
